// ===== hdl/emulated_memory_map_access_macros.svh =====
// ----------------------------------------------------------------------------
// emulated memory map access assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef EMULATED_MEMORY_MAP_ACCESS_MACROS_SVH
`define EMULATED_MEMORY_MAP_ACCESS_MACROS_SVH

// same-cycle implication, reset disables
`define EMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables
`define EMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/emm_pkg.sv =====
// ----------------------------------------------------------------------------
// emm_pkg
// types, region map and codes of the emulated memory map
// ----------------------------------------------------------------------------
package emm_pkg;

  localparam int PROG_FLASH_BYTES = 2097152;
  localparam int EXT_FLASH_BYTES  = 4194304;
  localparam int RAM_BYTES        = 65536;
  localparam int STACK_SIZE       = 256;

  localparam int NUM_REGIONS = 6;

  localparam int FLASH_AW = $clog2(PROG_FLASH_BYTES);
  localparam int EXT_AW   = $clog2(EXT_FLASH_BYTES);
  localparam int RAM_AW   = $clog2(RAM_BYTES);
  localparam int STACK_AW = $clog2(STACK_SIZE);

  localparam int MAX_FLASH = (PROG_FLASH_BYTES > EXT_FLASH_BYTES) ?
                             PROG_FLASH_BYTES : EXT_FLASH_BYTES;
  localparam int MAX_DATA  = (RAM_BYTES > STACK_SIZE) ? RAM_BYTES : STACK_SIZE;
  localparam int MAX_LEN   = (MAX_FLASH > MAX_DATA) ? MAX_FLASH : MAX_DATA;
  localparam int OFF_W     = $clog2(MAX_LEN);

  localparam int CLR_COUNT = MAX_DATA;
  localparam int CLR_W     = $clog2(CLR_COUNT);

  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_PRELOAD = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  localparam logic [2:0] REG_FLASH0   = 3'd0;
  localparam logic [2:0] REG_FLASH1   = 3'd1;
  localparam logic [2:0] REG_EXTFLASH = 3'd2;
  localparam logic [2:0] REG_CORE_RAM = 3'd3;
  localparam logic [2:0] REG_DATA_RAM = 3'd4;
  localparam logic [2:0] REG_STACK    = 3'd5;
  localparam logic [2:0] REG_NONE     = 3'd6;

  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_MAP = 2'd1;
  localparam logic [1:0] ERR_RO  = 2'd2;

  localparam logic [31:0] BASE_FLASH0   = 32'h8000_0000;
  localparam logic [31:0] BASE_FLASH1   = 32'h8080_0000;
  localparam logic [31:0] BASE_EXTFLASH = 32'h8400_0000;
  localparam logic [31:0] BASE_CORE_RAM = 32'hC000_0000;
  localparam logic [31:0] BASE_DATA_RAM = 32'hD000_0000;
  localparam logic [31:0] BASE_STACK    = 32'h0008_0000;

  localparam logic [31:0] REGION_BASE [NUM_REGIONS] = '{
    BASE_FLASH0, BASE_FLASH1, BASE_EXTFLASH,
    BASE_CORE_RAM, BASE_DATA_RAM, BASE_STACK
  };

  localparam logic [31:0] REGION_LAST [NUM_REGIONS] = '{
    32'(BASE_FLASH0   + 32'(PROG_FLASH_BYTES) - 32'd1),
    32'(BASE_FLASH1   + 32'(PROG_FLASH_BYTES) - 32'd1),
    32'(BASE_EXTFLASH + 32'(EXT_FLASH_BYTES)  - 32'd1),
    32'(BASE_CORE_RAM + 32'(RAM_BYTES)        - 32'd1),
    32'(BASE_DATA_RAM + 32'(RAM_BYTES)        - 32'd1),
    32'(BASE_STACK    + 32'(STACK_SIZE)       - 32'd1)
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  size_code;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  region_hit;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [2:0]       region;
    logic [OFF_W-1:0] off;
    logic [7:0]       wbyte;
  } mem_req_t;

endpackage

// ===== hdl/emm_ram.sv =====
// ----------------------------------------------------------------------------
// emm_ram
// generic byte-wide single-port ram with registered read data
// ----------------------------------------------------------------------------
module emm_ram #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hdl/emm_store.sv =====
// ----------------------------------------------------------------------------
// emm_store
// six region memories, post-reset clear of the rams, read byte select
// ----------------------------------------------------------------------------
module emm_store
  import emm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output logic     clr_busy,
  output logic [7:0] rd_byte
);

  logic [CLR_W-1:0] clr_idx;
  logic [2:0]       rd_region;
  logic             clr_ram;
  logic             clr_stack;
  logic             rd_issue;

  logic       en_f0, en_f1, en_ext, en_core, en_data, en_stk;
  logic       we_core, we_data, we_stk;
  logic [7:0] wd_core, wd_data, wd_stk;
  logic [RAM_AW-1:0]   a_core, a_data;
  logic [STACK_AW-1:0] a_stk;
  logic [7:0] q_f0, q_f1, q_ext, q_core, q_data, q_stk;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= CLR_W'(clr_idx + 1'b1);
      if ({1'b0, clr_idx} == (CLR_W+1)'(CLR_COUNT - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign clr_ram   = clr_busy && ({1'b0, clr_idx} < (CLR_W+1)'(RAM_BYTES));
  assign clr_stack = clr_busy && ({1'b0, clr_idx} < (CLR_W+1)'(STACK_SIZE));
  assign rd_issue  = req.en && !req.we;

  always_comb begin
    en_f0   = req.en && (req.region == REG_FLASH0);
    en_f1   = req.en && (req.region == REG_FLASH1);
    en_ext  = req.en && (req.region == REG_EXTFLASH);
    en_core = clr_ram || (req.en && (req.region == REG_CORE_RAM));
    en_data = clr_ram || (req.en && (req.region == REG_DATA_RAM));
    en_stk  = clr_stack || (req.en && (req.region == REG_STACK));
    we_core = clr_busy || req.we;
    we_data = clr_busy || req.we;
    we_stk  = clr_busy || req.we;
    wd_core = clr_busy ? 8'h00 : req.wbyte;
    wd_data = clr_busy ? 8'h00 : req.wbyte;
    wd_stk  = clr_busy ? 8'h00 : req.wbyte;
    a_core  = clr_busy ? clr_idx[RAM_AW-1:0]   : req.off[RAM_AW-1:0];
    a_data  = clr_busy ? clr_idx[RAM_AW-1:0]   : req.off[RAM_AW-1:0];
    a_stk   = clr_busy ? clr_idx[STACK_AW-1:0] : req.off[STACK_AW-1:0];
  end

  emm_ram #(.DEPTH(PROG_FLASH_BYTES)) u_flash0 (
    .clk(clk), .en(en_f0), .we(req.we), .addr(req.off[FLASH_AW-1:0]),
    .wdata(req.wbyte), .rdata(q_f0)
  );

  emm_ram #(.DEPTH(PROG_FLASH_BYTES)) u_flash1 (
    .clk(clk), .en(en_f1), .we(req.we), .addr(req.off[FLASH_AW-1:0]),
    .wdata(req.wbyte), .rdata(q_f1)
  );

  emm_ram #(.DEPTH(EXT_FLASH_BYTES)) u_extflash (
    .clk(clk), .en(en_ext), .we(req.we), .addr(req.off[EXT_AW-1:0]),
    .wdata(req.wbyte), .rdata(q_ext)
  );

  emm_ram #(.DEPTH(RAM_BYTES)) u_core_ram (
    .clk(clk), .en(en_core), .we(we_core), .addr(a_core),
    .wdata(wd_core), .rdata(q_core)
  );

  emm_ram #(.DEPTH(RAM_BYTES)) u_data_ram (
    .clk(clk), .en(en_data), .we(we_data), .addr(a_data),
    .wdata(wd_data), .rdata(q_data)
  );

  emm_ram #(.DEPTH(STACK_SIZE)) u_stack (
    .clk(clk), .en(en_stk), .we(we_stk), .addr(a_stk),
    .wdata(wd_stk), .rdata(q_stk)
  );

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_region <= req.region;
    end
  end

  always_comb begin
    case (rd_region)
      REG_FLASH0:   rd_byte = q_f0;
      REG_FLASH1:   rd_byte = q_f1;
      REG_EXTFLASH: rd_byte = q_ext;
      REG_CORE_RAM: rd_byte = q_core;
      REG_DATA_RAM: rd_byte = q_data;
      REG_STACK:    rd_byte = q_stk;
      default:      rd_byte = 8'h00;
    endcase
  end

endmodule

// ===== hdl/emm_seq.sv =====
// ----------------------------------------------------------------------------
// emm_seq
// access sequencer: region search, bounds check, byte loop, result register
// ----------------------------------------------------------------------------
module emm_seq
  import emm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  output mem_req_t   req,
  input  logic [7:0] rd_byte,
  input  logic       clr_busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_ACCESS = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state;
  in_item_t         item;
  logic [2:0]       r;
  logic [2:0]       region;
  logic [OFF_W-1:0] cur_off;
  logic [1:0]       idx;
  logic [1:0]       last_idx;
  logic [31:0]      rdata;
  logic [1:0]       err;
  logic             rd_pend;
  logic [1:0]       rd_lane;
  logic             is_write;
  logic [32:0]      end_addr;
  logic             hit;

  assign in_ready = (state == S_IDLE) && !clr_busy;
  assign is_write = (item.command == CMD_WRITE) || (item.command == CMD_PRELOAD);
  assign hit      = (item.address >= REGION_BASE[r]) && (item.address <= REGION_LAST[r]);
  assign end_addr = {1'b0, item.address} + 33'(last_idx);

  always_comb begin
    req.en     = (state == S_ACCESS);
    req.we     = is_write;
    req.region = region;
    req.off    = cur_off;
    req.wbyte  = item.write_data[{idx, 3'b000} +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= (state == S_ACCESS) && !is_write;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (hit) begin
            state <= S_CHECK;
          end else if (r == REG_STACK) begin
            state <= S_DONE;
          end
        end
        S_CHECK: begin
          if (end_addr > {1'b0, REGION_LAST[region]}) begin
            state <= S_DONE;
          end else if ((item.command == CMD_WRITE) && (region <= REG_EXTFLASH)) begin
            state <= S_DONE;
          end else begin
            state <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          if (idx == last_idx) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      rdata[{rd_lane, 3'b000} +: 8] <= rd_byte;
    end
    rd_lane <= idx;
    case (state)
      S_IDLE: begin
        item <= in_data;
        r    <= REG_FLASH0;
        case (in_data.size_code)
          SIZE_BYTE: last_idx <= 2'd0;
          SIZE_HALF: last_idx <= 2'd1;
          default:   last_idx <= 2'd3;
        endcase
      end
      S_DECODE: begin
        if (hit) begin
          region  <= r;
          cur_off <= OFF_W'(item.address - REGION_BASE[r]);
        end else if (r == REG_STACK) begin
          region <= REG_NONE;
          err    <= ERR_MAP;
          rdata  <= '0;
        end else begin
          r <= 3'(r + 3'd1);
        end
      end
      S_CHECK: begin
        rdata <= '0;
        idx   <= '0;
        if (end_addr > {1'b0, REGION_LAST[region]}) begin
          err <= ERR_MAP;
        end else if ((item.command == CMD_WRITE) && (region <= REG_EXTFLASH)) begin
          err <= ERR_RO;
        end else begin
          err <= ERR_OK;
        end
      end
      S_ACCESS: begin
        idx     <= 2'(idx + 2'd1);
        cur_off <= OFF_W'(cur_off + 1'b1);
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.read_data  <= rdata;
          out_data.region_hit <= region;
          out_data.error_code <= err;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/emulated_memory_map_access.sv =====
// ----------------------------------------------------------------------------
// emulated_memory_map_access
// memory map of an emulated microcontroller: six regions, byte-serial access
// ----------------------------------------------------------------------------
//   channel   signals                       payload
//   in        in_valid / in_ready           in_data  (in_item_t)
//   out       out_valid / out_ready         out_data (out_item_t)
//
// region search compares one region per cycle in order 0..5, then one byte
// per cycle on the single memory port: a hit that passes the bounds and
// read-only checks goes through the byte loop and a drain state, while an
// unmapped address or a range or read-only error goes straight to the
// result; a new transaction can be taken the cycle after it is registered.
// after reset the rams are cleared to zero, with in_ready held low.
// a result held in the output register stalls only the end of the next one.
// ----------------------------------------------------------------------------
module emulated_memory_map_access
  import emm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  mem_req_t   req;
  logic [7:0] rd_byte;
  logic       clr_busy;

  emm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .req      (req),
    .rd_byte  (rd_byte),
    .clr_busy (clr_busy)
  );

  emm_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .clr_busy(clr_busy),
    .rd_byte (rd_byte)
  );

endmodule

// ===== hdl/emm_checker.sv =====
// ----------------------------------------------------------------------------
// emm_checker
// port-level checks of the memory map, bound to the top level
// ----------------------------------------------------------------------------
`include "emulated_memory_map_access_macros.svh"

module emm_checker
  import emm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `EMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `EMM_ASSERT_NOW(a_err_zero, out_valid && (out_data.error_code != ERR_OK), out_data.read_data == 32'd0, "failed transaction returned data")
  `EMM_ASSERT_NOW(a_none_map, out_valid && (out_data.region_hit == REG_NONE), out_data.error_code == ERR_MAP, "unmapped address without error")
  `EMM_ASSERT_NOW(a_ro_flash, out_valid && (out_data.error_code == ERR_RO), out_data.region_hit <= REG_EXTFLASH, "read-only error outside flash")
  `EMM_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "new transaction taken while busy")

endmodule

bind emulated_memory_map_access emm_checker u_checker (.*);

// ===== dv/emulated_memory_map_access_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// emulated_memory_map_access_tb
// Drives read, write, preload and spare transactions into the memory map and
// checks each result against a byte-level image of all six regions kept in
// the bench. Directed edge cases come first, then mostly well-formed random
// traffic with random idling on both sides, a long output stall and a drain.
// ----------------------------------------------------------------------------
module emulated_memory_map_access_tb
  import emm_pkg::*;
;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam logic [1:0] SIZE_WORD   = 2'd2;
  localparam logic [1:0] SIZE_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [7:0]  byte_image [logic [31:0]];
  logic [31:0] flash_filled_q [$];
  out_item_t   expected_q [$];
  out_item_t   head_item;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          hold_len = 0;
  bit          calm = 1'b0;

  emulated_memory_map_access uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [2:0] area_of(logic [31:0] addr);
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (addr >= REGION_BASE[r] && addr <= REGION_LAST[r]) return 3'(r);
    end
    return REG_NONE;
  endfunction

  function automatic int unsigned access_bytes(logic [1:0] size_code);
    return (size_code == SIZE_BYTE) ? 1 : (size_code == SIZE_HALF) ? 2 : 4;
  endfunction

  function automatic bit runs_past_end(logic [31:0] addr, int unsigned n, logic [2:0] area);
    return ({1'b0, addr} + 33'(n) - 33'd1) > {1'b0, REGION_LAST[area]};
  endfunction

  // updates the region image as a side effect
  function automatic out_item_t predict_access(in_item_t a);
    out_item_t   res;
    int unsigned n;
    logic [2:0]  area;
    logic [31:0] at;
    bit          stores;
    n = access_bytes(a.size_code);
    area = area_of(a.address);
    stores = (a.command == CMD_WRITE || a.command == CMD_PRELOAD);
    res.read_data = '0;
    res.region_hit = area;
    res.error_code = ERR_MAP;
    if (area != REG_NONE && !runs_past_end(a.address, n, area)) begin
      if (a.command == CMD_WRITE && area <= REG_EXTFLASH) begin
        res.error_code = ERR_RO;
      end else begin
        res.error_code = ERR_OK;
        for (int i = 0; i < n; i++) begin
          at = a.address + 32'(i);
          if (stores) begin
            if (area <= REG_EXTFLASH && !byte_image.exists(at)) flash_filled_q.push_back(at);
            byte_image[at] = a.write_data[8*i +: 8];
          end else if (byte_image.exists(at)) begin
            res.read_data[8*i +: 8] = byte_image[at];
          end
        end
      end
    end
    return res;
  endfunction

  // a flash read that would touch a never-preloaded byte is not allowed
  function automatic bit flash_bytes_ready(in_item_t a);
    int unsigned n;
    logic [2:0]  area;
    n = access_bytes(a.size_code);
    area = area_of(a.address);
    if (area > REG_EXTFLASH || runs_past_end(a.address, n, area)) return 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!byte_image.exists(a.address + 32'(i))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic in_item_t random_access();
    in_item_t    a;
    int unsigned pick;
    int unsigned mode;
    logic [2:0]  area;
    pick = $urandom_range(99);
    a.command = (pick < 40) ? CMD_READ : (pick < 65) ? CMD_WRITE :
                (pick < 90) ? CMD_PRELOAD : CMD_SPARE;
    a.size_code = 2'($urandom_range(3));
    a.write_data = $urandom;
    pick = $urandom_range(19);
    area = (pick < 18) ? 3'(pick % 6) : REG_NONE;
    mode = $urandom_range(9);
    if (area == REG_NONE) begin
      pick = $urandom_range(NUM_REGIONS - 1);
      if (mode < 5) begin
        do a.address = $urandom; while (area_of(a.address) != REG_NONE);
      end else if (mode < 8) begin
        a.address = REGION_BASE[pick] - 32'($urandom_range(1, 4));
      end else begin
        a.address = REGION_LAST[pick] + 32'($urandom_range(1, 4));
      end
    end else if (mode < 4) begin
      a.address = REGION_BASE[area] + 32'($urandom_range(31));
    end else if (mode < 6) begin
      a.address = REGION_LAST[area] - 32'($urandom_range(7));
    end else if (mode < 8 && area <= REG_EXTFLASH && flash_filled_q.size() > 0) begin
      a.address = flash_filled_q[$urandom_range(flash_filled_q.size() - 1)] -
                  32'($urandom_range(3));
    end else begin
      a.address = REGION_BASE[area] +
                  ($urandom % (REGION_LAST[area] - REGION_BASE[area] + 32'd1));
    end
    if ((a.command == CMD_READ || a.command == CMD_SPARE) && !flash_bytes_ready(a))
      a.command = CMD_PRELOAD;
    return a;
  endfunction

  task automatic send_access(in_item_t item);
    bit lowered;
    lowered = 1'b0;
    while (!calm && $urandom_range(99) < 23) begin
      if (!lowered) in_valid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
    expected_q.push_back(predict_access(item));
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic issue(logic [1:0] cmd, logic [1:0] size, logic [31:0] addr,
                       logic [31:0] data);
    send_access(in_item_t'{cmd, size, addr, data});
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic test_ram_access();
    issue(CMD_WRITE,   SIZE_WORD,  BASE_CORE_RAM, 32'hDEAD_BEEF);
    issue(CMD_READ,    SIZE_BYTE,  BASE_CORE_RAM + 32'd1, '0);
    issue(CMD_READ,    SIZE_HALF,  BASE_CORE_RAM + 32'd2, '0);
    issue(CMD_READ,    SIZE_SPARE, BASE_CORE_RAM, '0);
    issue(CMD_WRITE,   SIZE_BYTE,  REGION_LAST[REG_DATA_RAM], 32'hFFFF_FFA5);
    issue(CMD_SPARE,   SIZE_BYTE,  REGION_LAST[REG_DATA_RAM], '0);
    issue(CMD_READ,    SIZE_WORD,  BASE_STACK, '0);
    issue(CMD_PRELOAD, SIZE_WORD,  REGION_LAST[REG_STACK] - 32'd3, 32'hFFFF_FFFF);
    issue(CMD_READ,    SIZE_HALF,  REGION_LAST[REG_STACK] - 32'd1, '0);
    issue(CMD_READ,    SIZE_WORD,  BASE_DATA_RAM, '0);
  endtask

  task automatic test_flash_preload();
    issue(CMD_PRELOAD, SIZE_WORD, BASE_FLASH0, 32'h0123_4567);
    issue(CMD_READ,    SIZE_WORD, BASE_FLASH0, '0);
    issue(CMD_PRELOAD, SIZE_HALF, REGION_LAST[REG_FLASH1] - 32'd1, 32'h5A5A_A5C3);
    issue(CMD_READ,    SIZE_HALF, REGION_LAST[REG_FLASH1] - 32'd1, '0);
    issue(CMD_PRELOAD, SIZE_BYTE, REGION_LAST[REG_EXTFLASH], 32'h0000_00FE);
    issue(CMD_SPARE,   SIZE_BYTE, REGION_LAST[REG_EXTFLASH], '0);
    issue(CMD_WRITE,   SIZE_WORD, BASE_FLASH0, 32'hFFFF_FFFF);
    issue(CMD_WRITE,   SIZE_BYTE, REGION_LAST[REG_FLASH1] - 32'd1, 32'h0000_0011);
  endtask

  task automatic test_map_errors();
    issue(CMD_WRITE,   SIZE_WORD, REGION_LAST[REG_STACK] - 32'd1, 32'h1234_5678);
    issue(CMD_READ,    SIZE_WORD, REGION_LAST[REG_EXTFLASH] - 32'd1, '0);
    issue(CMD_READ,    SIZE_BYTE, 32'h0000_0000, '0);
    issue(CMD_WRITE,   SIZE_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_READ,    SIZE_BYTE, BASE_STACK - 32'd1, '0);
    issue(CMD_READ,    SIZE_BYTE, REGION_LAST[REG_FLASH0] + 32'd1, '0);
    issue(CMD_PRELOAD, SIZE_HALF, REGION_LAST[REG_CORE_RAM], 32'hCAFE_F00D);
    issue(CMD_READ,    SIZE_BYTE, REGION_LAST[REG_CORE_RAM] + 32'd1, '0);
  endtask

  task automatic test_random_traffic();
    calm = 1'b1;
    for (int k = 0; k < 320; k++) begin
      if (k == 150) calm = 1'b0;
      send_access(random_access());
    end
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    repeat (40) send_access(random_access());
  endtask

  task automatic test_idle_drain();
    wait_for_results();
    repeat (10) send_access(random_access());
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        for (int k = 0; k < hold_len; k++) @(posedge clk);
        hold_len = 0;
      end
      out_ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("mismatch: unexpected transaction data %h region %0d error %0d",
                               out_data.read_data, out_data.region_hit, out_data.error_code));
      end else begin
        head_item = expected_q.pop_front();
        if (out_data.read_data !== head_item.read_data ||
            out_data.region_hit !== head_item.region_hit ||
            out_data.error_code !== head_item.error_code)
          log_mismatch($sformatf(
            "mismatch: data %h/%h region %0d/%0d error %0d/%0d (expected/actual)",
            head_item.read_data, out_data.read_data, head_item.region_hit,
            out_data.region_hit, head_item.error_code, out_data.error_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_ram_access();
    test_flash_preload();
    test_map_errors();
    test_random_traffic();
    test_backpressure();
    test_idle_drain();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
